[rtl/bdy_pkg.sv]
`timescale 1ns / 1ps
package bdy_pkg;
  localparam int unsigned PoolOrderDef   = 16;
  localparam int unsigned MinBlkOrderDef = 4;
  localparam int unsigned DataW          = 16;
  localparam int unsigned TagW           = 5;

  typedef struct packed {
    logic        we;
    logic [23:0] addr;
    logic [24:0] wdata;
  } link_wr_t;
endpackage

[rtl/bdy_link_mem.sv]
`timescale 1ns / 1ps
module bdy_link_mem
  import bdy_pkg::*;
#(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/buddy_allocator_unit.sv]
`timescale 1ns / 1ps
// Buddy allocator over a pool of 2^POOL_ORDER bytes.
// Input channel (in_valid_i/in_ready_o): mode_i, request_size_i, block_offset_i.
//   mode 0 allocates a block of at least request_size+1 bytes, mode 1 frees block_offset.
// Output channel (out_valid_o/out_ready_i): result_offset_o, failed_o.
// One result per item. Items are handled one at a time by a sequencer
// around two synchronous memories (next links and order tags, registered
// read) plus a small register file of list heads.
// Allocate: it scans orders one per cycle from the wanted order up to the
//   first non-empty list, pops that list's head, then splits one order per
//   cycle back down to the wanted order.
// Free: each merge level walks that order's free list, visiting each entry
//   in an FWALK and an FUNL state, so latency grows with list length.
// The result sits in an output register; a new item is accepted only once
// the previous result is taken, so a stalled receiver stalls the input.
// Reset empties every list except the top order, which holds block 0.
// No clearing pass is needed after reset.
module buddy_allocator_unit
  import bdy_pkg::*;
#(
  parameter int unsigned POOL_ORDER      = PoolOrderDef,
  parameter int unsigned MIN_BLOCK_ORDER = MinBlkOrderDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [DataW-1:0]     request_size_i,
  input  logic [DataW-1:0]     block_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataW-1:0]     result_offset_o,
  output logic                 failed_o
);
  localparam int unsigned EMin  = (MIN_BLOCK_ORDER < POOL_ORDER) ? MIN_BLOCK_ORDER
                                                                 : POOL_ORDER;
  localparam int unsigned IB    = (POOL_ORDER - EMin) > 0 ? (POOL_ORDER - EMin) : 1;
  localparam int unsigned NOrd  = POOL_ORDER - EMin + 1;
  localparam int unsigned OW    = (NOrd > 1) ? $clog2(NOrd) : 1;
  localparam int unsigned LW    = IB + 1;
  localparam int unsigned NBlk  = 2 ** IB;
  localparam int unsigned SW    = IB + 2;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_POP   = 10'b0000000100,
    S_SPLIT = 10'b0000001000,
    S_FTAG  = 10'b0000010000,
    S_FLVL  = 10'b0000100000,
    S_FWALK = 10'b0001000000,
    S_FUNL  = 10'b0010000000,
    S_FPUSH = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0] heads_q [NOrd];
  logic [TagW-1:0] ord_q, ord_d, want_q, want_d;
  logic [IB-1:0] blk_q, blk_d, buddy_q, buddy_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [IB-1:0] prev_q, prev_d;
  logic prev_is_head_q, prev_is_head_d;
  logic [SW-1:0] steps_q, steps_d;
  logic [DataW-1:0] res_q, res_d;
  logic fail_q, fail_d;
  logic out_v_q, out_v_d;
  logic link0_q;

  logic hw_en;
  logic [TagW-1:0] hw_ord;
  logic [TagW-1:0] hw_rel;
  logic [LW-1:0] hw_val;

  link_wr_t lwr;
  logic [IB-1:0] lraddr;
  logic [LW-1:0] lrdata;

  logic tg_we;
  logic [IB-1:0] tg_waddr, tg_raddr;
  logic [TagW-1:0] tg_wdata, tg_rdata;

  bdy_link_mem #(.AW(IB), .DW(LW)) u_links (
    .clk_i, .we_i(lwr.we), .waddr_i(lwr.addr[IB-1:0]),
    .wdata_i(lwr.wdata[LW-1:0]), .raddr_i(lraddr), .rdata_o(lrdata)
  );
  bdy_link_mem #(.AW(IB), .DW(TagW)) u_tags (
    .clk_i, .we_i(tg_we), .waddr_i(tg_waddr), .wdata_i(tg_wdata),
    .raddr_i(tg_raddr), .rdata_o(tg_rdata)
  );

  function automatic logic [TagW-1:0] size_order(input logic [DataW-1:0] s);
    logic [DataW:0] need;
    logic [TagW-1:0] o;
    need = {1'b0, s} + (DataW+1)'(1);
    o = '0;
    for (int i = DataW; i >= 0; i--) begin
      if (o == '0 && need > ((DataW+1)'(1) << i)) o = TagW'(i + 1);
    end
    if (need == (DataW+1)'(1)) o = '0;
    return o;
  endfunction

  logic [TagW-1:0] rel_o;
  logic [LW-1:0] head_cur;
  logic [TagW-1:0] tag_clamp;
  logic [IB-1:0] bit_at;
  logic [IB-1:0] half_bit;
  logic [IB-1:0] blk_mask;
  logic [IB-1:0] in_blk;

  assign rel_o    = ord_q - TagW'(EMin);
  assign head_cur = heads_q[rel_o[OW-1:0]];
  assign bit_at   = IB'(1) << rel_o;
  assign half_bit = IB'(1) << (rel_o - TagW'(1));
  assign in_blk   = IB'(block_offset_i >> EMin);
  assign hw_rel   = hw_ord - TagW'(EMin);

  always_comb begin
    tag_clamp = tg_rdata;
    if (tag_clamp < TagW'(EMin)) tag_clamp = TagW'(EMin);
    if (tag_clamp > TagW'(POOL_ORDER)) tag_clamp = TagW'(POOL_ORDER);
    blk_mask = ~((IB'(1) << (tag_clamp - TagW'(EMin))) - IB'(1));
  end

  always_comb begin
    state_d = state_q;
    ord_d = ord_q; want_d = want_q; blk_d = blk_q; buddy_d = buddy_q;
    cur_d = cur_q; prev_d = prev_q; prev_is_head_d = prev_is_head_q;
    steps_d = steps_q; res_d = res_q; fail_d = fail_q; out_v_d = out_v_q;
    hw_en = 1'b0; hw_ord = ord_q; hw_val = '0;
    lwr = '0; lraddr = '0;
    tg_we = 1'b0; tg_waddr = blk_q; tg_wdata = want_q; tg_raddr = in_blk;
    in_ready_o = (state_q == S_IDLE) && !out_v_q;
    if (out_v_q && out_ready_i) out_v_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          res_d = '0; fail_d = 1'b0;
          if (!mode_i) begin
            want_d = size_order(request_size_i);
            if (want_d < TagW'(EMin)) want_d = TagW'(EMin);
            ord_d = want_d;
            if (want_d > TagW'(POOL_ORDER)) begin
              fail_d = 1'b1; state_d = S_OUT;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            blk_d = in_blk;
            state_d = S_FTAG;
          end
        end
      end
      S_SCAN: begin
        if (head_cur[IB]) begin
          blk_d = head_cur[IB-1:0];
          lraddr = head_cur[IB-1:0];
          state_d = S_POP;
        end else if (ord_q == TagW'(POOL_ORDER)) begin
          fail_d = 1'b1; state_d = S_OUT;
        end else begin
          ord_d = ord_q + TagW'(1);
        end
      end
      S_POP: begin
        // block 0 from reset has no link written yet: end of list
        hw_en = 1'b1;
        hw_val = (blk_q == '0 && !link0_q) ? '0 : lrdata;
        state_d = S_SPLIT;
      end
      S_SPLIT: begin
        if (ord_q > want_q) begin
          hw_en = 1'b1;
          hw_ord = ord_q - TagW'(1);
          hw_val = {1'b1, blk_q ^ half_bit};
          lwr.we = 1'b1;
          lwr.addr = 24'(blk_q ^ half_bit);
          lwr.wdata = '0;
          ord_d = ord_q - TagW'(1);
        end else begin
          tg_we = 1'b1;
          res_d = DataW'(32'(blk_q) << EMin);
          state_d = S_OUT;
        end
      end
      S_FTAG: begin
        ord_d = tag_clamp;
        blk_d = blk_q & blk_mask;
        state_d = S_FLVL;
      end
      S_FLVL: begin
        if (ord_q == TagW'(POOL_ORDER)) begin
          state_d = S_FPUSH;
        end else begin
          buddy_d = blk_q ^ bit_at;
          cur_d = head_cur;
          prev_is_head_d = 1'b1;
          steps_d = '0;
          state_d = S_FWALK;
        end
      end
      S_FWALK: begin
        lraddr = cur_q[IB-1:0];
        if (!cur_q[IB] || steps_q >= SW'(NBlk)) begin
          state_d = S_FPUSH;
        end else if (cur_q[IB-1:0] == buddy_q) begin
          state_d = S_FUNL;
        end else begin
          prev_d = cur_q[IB-1:0];
          prev_is_head_d = 1'b0;
          steps_d = steps_q + SW'(1);
          cur_d = {1'b0, cur_q[IB-1:0]};
          state_d = S_FUNL;
        end
      end
      S_FUNL: begin
        if (cur_q[IB]) begin
          if (prev_is_head_q) begin
            hw_en = 1'b1; hw_val = lrdata;
          end else begin
            lwr.we = 1'b1; lwr.addr = 24'(prev_q); lwr.wdata = 25'(lrdata);
          end
          if (buddy_q < blk_q) blk_d = buddy_q;
          ord_d = ord_q + TagW'(1);
          state_d = S_FLVL;
        end else begin
          cur_d = lrdata;
          state_d = S_FWALK;
        end
      end
      S_FPUSH: begin
        lwr.we = 1'b1; lwr.addr = 24'(blk_q); lwr.wdata = 25'(head_cur);
        hw_en = 1'b1; hw_val = {1'b1, blk_q};
        state_d = S_OUT;
      end
      S_OUT: begin
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      link0_q <= 1'b0;
      for (int i = 0; i < NOrd; i++) begin
        heads_q[i] <= (i == int'(NOrd) - 1) ? {1'b1, {IB{1'b0}}} : '0;
      end
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      if (lwr.we && lwr.addr[IB-1:0] == '0) begin
        link0_q <= 1'b1;
      end
      if (hw_en) begin
        heads_q[hw_rel[OW-1:0]] <= hw_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q <= ord_d; want_q <= want_d; blk_q <= blk_d; buddy_q <= buddy_d;
    cur_q <= cur_d; prev_q <= prev_d; prev_is_head_q <= prev_is_head_d;
    steps_q <= steps_d; res_q <= res_d; fail_q <= fail_d;
  end

  assign out_valid_o     = out_v_q;
  assign result_offset_o = res_q;
  assign failed_o        = fail_q;
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import bdy_pkg::*;

  localparam int MinOrd   = 4;
  localparam int TopOrd   = 16;
  localparam int NumBlk   = 4096;
  localparam int StallMax = 400000;

  typedef enum logic {OpAlloc = 1'b0, OpFree = 1'b1} op_e;

  typedef struct {
    logic [DataW-1:0] offs;
    logic             fl;
  } alloc_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             mode_i = 1'b0;
  logic [DataW-1:0] request_size_i = '0;
  logic [DataW-1:0] block_offset_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [DataW-1:0] result_offset_o;
  logic             failed_o;

  buddy_allocator_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Allocator image
  logic [12:0] free_heads [13];
  logic [12:0] next_free  [NumBlk];
  logic [4:0]  blk_order  [NumBlk];

  alloc_res_t       pending_results [$];
  logic [DataW-1:0] live_blocks [$];
  logic [DataW-1:0] ever_blocks [$];

  int err_cnt, n_alloc, n_fail, n_free, n_results;
  int snd_idle_pct, rcv_idle_pct, hold_cycles, stall_cnt;

  task automatic report(input string what);
    err_cnt++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic void image_reset();
    for (int i = 0; i < 13; i++) free_heads[i] = '0;
    for (int i = 0; i < NumBlk; i++) begin
      next_free[i] = '0;
      blk_order[i] = '0;
    end
    free_heads[12] = 13'h1000;
  endfunction

  function automatic alloc_res_t alloc_block(input logic [15:0] size);
    alloc_res_t r;
    int need, ord, j;
    logic [11:0] blk, half;
    r.offs = '0;
    r.fl   = 1'b1;
    need = int'(size) + 1;
    ord = 0;
    while (ord < 31 && (1 << ord) < need) ord++;
    if (ord < MinOrd) ord = MinOrd;
    if (ord > TopOrd) return r;
    for (j = ord; j <= TopOrd; j++) if (free_heads[j-MinOrd][12]) break;
    if (j > TopOrd) return r;
    blk = free_heads[j-MinOrd][11:0];
    free_heads[j-MinOrd] = next_free[blk];
    for (int k = j; k > ord; k--) begin
      half = blk ^ 12'(1 << (k - 1 - MinOrd));
      free_heads[k-1-MinOrd] = {1'b1, half};
      next_free[half] = '0;
    end
    blk_order[blk] = 5'(ord);
    r.offs = {blk, 4'b0};
    r.fl = 1'b0;
    return r;
  endfunction

  function automatic void free_block(input logic [15:0] offs);
    logic [11:0] blk, buddy;
    logic [12:0] cur, nv;
    int ord, prev, steps;
    bit found;
    blk = offs[15:4];
    ord = int'(blk_order[blk]);
    if (ord < MinOrd) ord = MinOrd;
    if (ord > TopOrd) ord = TopOrd;
    blk &= ~12'((1 << (ord - MinOrd)) - 1);
    while (ord < TopOrd) begin
      buddy = blk ^ 12'(1 << (ord - MinOrd));
      cur = free_heads[ord-MinOrd];
      prev = -1;
      steps = 0;
      found = 1'b0;
      while (cur[12] && steps < NumBlk) begin
        if (cur[11:0] == buddy) begin
          found = 1'b1;
          break;
        end
        prev = int'(cur[11:0]);
        cur = next_free[cur[11:0]];
        steps++;
      end
      if (!found) break;
      nv = next_free[buddy];
      if (prev < 0) free_heads[ord-MinOrd] = nv;
      else next_free[prev] = nv;
      if (buddy < blk) blk = buddy;
      ord++;
    end
    next_free[blk] = free_heads[ord-MinOrd];
    free_heads[ord-MinOrd] = {1'b1, blk};
  endfunction

  task automatic send_item(input op_e op, input logic [15:0] size, input logic [15:0] offs);
    alloc_res_t r;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= op;
    request_size_i <= size;
    block_offset_i <= offs;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpAlloc) begin
      r = alloc_block(size);
      n_alloc++;
      if (r.fl) n_fail++;
      else begin
        live_blocks.push_back(r.offs);
        ever_blocks.push_back(r.offs);
      end
    end else begin
      free_block(offs);
      r.offs = '0;
      r.fl = 1'b0;
      n_free++;
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic free_live(input int idx, input logic [3:0] low_bits);
    logic [15:0] o;
    o = live_blocks[idx] | {12'b0, low_bits};
    live_blocks.delete(idx);
    send_item(OpFree, 16'($urandom()), o);
  endtask

  task automatic random_item();
    int p;
    logic [15:0] sz;
    p = $urandom_range(0, 99);
    if (p < 55 || live_blocks.size() == 0) begin
      case ($urandom_range(0, 9))
        0:       sz = 16'($urandom());
        1, 2:    sz = 16'($urandom_range(256, 4095));
        default: sz = 16'($urandom_range(0, 255));
      endcase
      send_item(OpAlloc, sz, 16'($urandom()));
    end else if (p < 95) begin
      free_live($urandom_range(0, live_blocks.size() - 1), 4'b0);
    end else if (p < 98) begin
      free_live($urandom_range(0, live_blocks.size() - 1), 4'($urandom()));
    end else begin
      send_item(OpFree, 16'($urandom()),
                ever_blocks[$urandom_range(0, ever_blocks.size() - 1)]);
    end
  endtask

  task automatic test_directed();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_item(OpAlloc, 16'hffff, 16'h0000);
    send_item(OpAlloc, 16'h0000, 16'hffff);
    send_item(OpFree, 16'hffff, live_blocks.pop_front());
    send_item(OpFree, 16'h0000, 16'h0000);
    send_item(OpAlloc, 16'h0000, 16'h0000);
    send_item(OpAlloc, 16'h000f, 16'h0000);
    send_item(OpAlloc, 16'h0010, 16'h0000);
    send_item(OpAlloc, 16'h7fff, 16'h0000);
    send_item(OpAlloc, 16'h7fff, 16'h0000);
    send_item(OpAlloc, 16'h00ff, 16'h0000);
    free_live(1, 4'hf);
    free_live(0, 4'h0);
    free_live(0, 4'h5);
    send_item(OpFree, 16'h0, ever_blocks[1]);
    while (live_blocks.size() != 0) free_live(0, 4'h0);
    for (int i = 0; i < 6; i++) send_item(OpAlloc, 16'h3fff, 16'h0);
    while (live_blocks.size() != 0) free_live(0, 4'h0);
    wait_idle();
  endtask

  task automatic test_random(input int snd, input int rcv, input int n);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    repeat (n) random_item();
    wait_idle();
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles = 300;
    repeat (8) random_item();
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    alloc_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_r = pending_results.pop_front();
        if (result_offset_o !== exp_r.offs)
          report($sformatf("result_offset %h, expected %h", result_offset_o, exp_r.offs));
        if (failed_o !== exp_r.fl)
          report($sformatf("failed %b, expected %b", failed_o, exp_r.fl));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallMax) begin
      $display("watchdog: no progress for %0d cycles", StallMax);
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    image_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(32, 55, 130);
    test_backpressure();
    test_random(55, 32, 130);
    test_random(0, 0, 130);
    repeat (50) @(posedge clk_i);
    $display("covered %0d allocations (%0d failed) and %0d frees, %0d results checked",
             n_alloc, n_fail, n_free, n_results);
    $display("idle mixes: sender/receiver 32/55, 55/32, 0/0, plus a long output stall");
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
